FILE: rtl/dtip_pkg.sv
package dtip_pkg;

  // Operation codes carried by the opcode field.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register map.
  localparam logic [3:0] REG_TA_LO = 4'd4;
  localparam logic [3:0] REG_TA_HI = 4'd5;
  localparam logic [3:0] REG_TB_LO = 4'd6;
  localparam logic [3:0] REG_TB_HI = 4'd7;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  // Control and interrupt register bit positions.
  localparam int BIT_RUN   = 0;
  localparam int BIT_LOAD  = 4;
  localparam int BIT_SRC   = 5;
  localparam int BIT_SETCL = 7;

  // Result of one timer's tick evaluation.
  typedef struct packed {
    logic [15:0] count_next;
    logic        underflow;
  } dtip_tick_t;

endpackage

FILE: rtl/dtip_timer.sv
module dtip_timer
  import dtip_pkg::*;
(
  input  logic [15:0] count,
  input  logic [15:0] latch,
  input  logic        active,
  input  logic [7:0]  elapsed_cycles,
  output dtip_tick_t  tick
);

  logic [15:0] elapsed_ext;

  assign elapsed_ext = {8'h00, elapsed_cycles};

  // Count down by the elapsed cycles; reload from the latch at or below zero.
  always_comb begin
    tick.count_next = count;
    tick.underflow  = 1'b0;
    if (active) begin
      if (count <= elapsed_ext) begin
        tick.count_next = latch;
        tick.underflow  = 1'b1;
      end else begin
        tick.count_next = count - elapsed_ext;
      end
    end
  end

endmodule

FILE: rtl/dual_timer_interrupt_peripheral.sv
// Two 16-bit down-counting timers with byte-wide latches, an interrupt mask
// and an interrupt status register. Each input transfer is a tick carrying
// elapsed processor cycles, a register read or a register write, and each
// produces exactly one result transfer (read_data, irq_pulse). An item passes
// an input register and then a result register, so one item is taken every
// clock unless out_ready holds the result register back; the result register
// holds under back-pressure while the input register keeps accepting one more.
// Reading the status register (13) returns the flags and clears them. Timers
// count only when running with input source 0 (processor clock).
module dual_timer_interrupt_peripheral
  import dtip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [3:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [7:0] elapsed_cycles,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       irq_pulse
);

  // Input register.
  logic       item_valid;
  logic [1:0] item_op;
  logic [3:0] item_addr;
  logic [7:0] item_data;
  logic [7:0] item_elapsed;

  // Timer state.
  logic [15:0] latch_a, latch_b, count_a, count_b;
  logic        run_a, run_b, mask_a, mask_b, flag_a, flag_b;
  logic        source_a;
  logic [1:0]  source_b;

  logic [15:0] latch_a_next, latch_b_next, count_a_next, count_b_next;
  logic        run_a_next, run_b_next, mask_a_next, mask_b_next;
  logic        flag_a_next, flag_b_next;
  logic        source_a_next;
  logic [1:0]  source_b_next;
  logic [7:0]  rd_next;
  logic        irq_next;

  logic       advance;
  dtip_tick_t tick_a, tick_b;

  // The item moves into the result register when that register is free or being read out.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_op      <= opcode;
      item_addr    <= reg_addr;
      item_data    <= write_data;
      item_elapsed <= elapsed_cycles;
    end
  end

  dtip_timer u_timer_a (
    .count          (count_a),
    .latch          (latch_a),
    .active         (run_a && !source_a),
    .elapsed_cycles (item_elapsed),
    .tick           (tick_a)
  );

  dtip_timer u_timer_b (
    .count          (count_b),
    .latch          (latch_b),
    .active         (run_b && (source_b == 2'd0)),
    .elapsed_cycles (item_elapsed),
    .tick           (tick_b)
  );

  // Next state and result for the item in the input register.
  always_comb begin
    latch_a_next  = latch_a;
    latch_b_next  = latch_b;
    count_a_next  = count_a;
    count_b_next  = count_b;
    run_a_next    = run_a;
    run_b_next    = run_b;
    mask_a_next   = mask_a;
    mask_b_next   = mask_b;
    flag_a_next   = flag_a;
    flag_b_next   = flag_b;
    source_a_next = source_a;
    source_b_next = source_b;
    rd_next       = 8'h00;
    irq_next      = 1'b0;
    unique case (item_op)
      OP_TICK: begin
        count_a_next = tick_a.count_next;
        count_b_next = tick_b.count_next;
        if (tick_a.underflow) begin
          flag_a_next = 1'b1;
        end
        if (tick_b.underflow) begin
          flag_b_next = 1'b1;
        end
        irq_next = (tick_a.underflow && mask_a) || (tick_b.underflow && mask_b);
      end
      OP_READ: begin
        unique case (item_addr)
          REG_TA_LO: rd_next = count_a[7:0];
          REG_TA_HI: rd_next = count_a[15:8];
          REG_TB_LO: rd_next = count_b[7:0];
          REG_TB_HI: rd_next = count_b[15:8];
          REG_ICR: begin
            rd_next = {(flag_a && mask_a) || (flag_b && mask_b), 5'b00000,
                       flag_b, flag_a};
            flag_a_next = 1'b0;
            flag_b_next = 1'b0;
          end
          default: rd_next = 8'h00;
        endcase
      end
      OP_WRITE: begin
        unique case (item_addr)
          REG_TA_LO: latch_a_next = {latch_a[15:8], item_data};
          REG_TA_HI: latch_a_next = {item_data, latch_a[7:0]};
          REG_TB_LO: latch_b_next = {latch_b[15:8], item_data};
          REG_TB_HI: latch_b_next = {item_data, latch_b[7:0]};
          REG_ICR: begin
            if (item_data[0]) begin
              mask_a_next = item_data[BIT_SETCL];
            end
            if (item_data[1]) begin
              mask_b_next = item_data[BIT_SETCL];
            end
          end
          REG_CRA: begin
            run_a_next    = item_data[BIT_RUN];
            source_a_next = item_data[BIT_SRC];
            if (item_data[BIT_LOAD]) begin
              count_a_next = latch_a;
            end
          end
          REG_CRB: begin
            run_b_next    = item_data[BIT_RUN];
            source_b_next = item_data[BIT_SRC+1:BIT_SRC];
            if (item_data[BIT_LOAD]) begin
              count_b_next = latch_b;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a   <= 16'h0000;
      latch_b   <= 16'h0000;
      count_a   <= 16'h0000;
      count_b   <= 16'h0000;
      run_a     <= 1'b0;
      run_b     <= 1'b0;
      mask_a    <= 1'b0;
      mask_b    <= 1'b0;
      flag_a    <= 1'b0;
      flag_b    <= 1'b0;
      source_a  <= 1'b0;
      source_b  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        latch_a   <= latch_a_next;
        latch_b   <= latch_b_next;
        count_a   <= count_a_next;
        count_b   <= count_b_next;
        run_a     <= run_a_next;
        run_b     <= run_b_next;
        mask_a    <= mask_a_next;
        mask_b    <= mask_b_next;
        flag_a    <= flag_a_next;
        flag_b    <= flag_b_next;
        source_a  <= source_a_next;
        source_b  <= source_b_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      read_data <= rd_next;
      irq_pulse <= irq_next;
    end
  end

  // An interrupt pulse only comes from a tick, which never returns read data.
  a_irq_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_pulse |-> read_data == 8'h00)
    else $error("irq_pulse with nonzero read_data");

  // A status read leaves both flags clear.
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    advance && item_op == OP_READ && item_addr == REG_ICR |=> !flag_a && !flag_b)
    else $error("status flags not cleared by read");

  // An underflow of timer A on a tick sets its flag.
  a_flag_a_set: assert property (@(posedge clk) disable iff (rst)
    advance && item_op == OP_TICK && tick_a.underflow |=> flag_a)
    else $error("timer A underflow did not set flag");

  // With the result register empty, the input side is never stalled.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import dtip_pkg::*;

  // The opcode value that the block treats as a no-op.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1950;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } timer_result_t;

  typedef struct {
    logic [1:0] op;
    logic [3:0] addr;
    logic [7:0] data;
    logic [7:0] elapsed;
    bit         wait_drain;
  } bus_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] opcode = '0;
  logic [3:0] reg_addr = '0;
  logic [7:0] write_data = '0;
  logic [7:0] elapsed_cycles = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       irq_pulse;

  dual_timer_interrupt_peripheral uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .reg_addr(reg_addr),
    .write_data(write_data), .elapsed_cycles(elapsed_cycles),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .irq_pulse(irq_pulse)
  );

  // Shadow copy of the timer state, index 0 for timer A and 1 for timer B.
  logic [15:0] tmr_latch [2];
  logic [15:0] tmr_count [2];
  logic [1:0]  tmr_src [2];
  bit          tmr_run [2];
  bit          irq_mask [2];
  bit          irq_flag [2];

  bus_item_t     pending_items[$];
  timer_result_t expected_results[$];

  int  err_count = 0;
  int  taken_count = 0;
  int  idle_pct = 30;
  bit  item_taken = 0;
  int  hold_cycles = 0;
  bit  hold_done = 0;
  int  live_items = 0;
  bit  drain_next = 0;
  int  n_ticks = 0, n_reads = 0, n_writes = 0, n_irq = 0, n_flag_reads = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Counts one timer down by the elapsed cycles; returns 1 on underflow.
  function automatic bit timer_expired(int k, logic [7:0] el);
    if (!tmr_run[k] || tmr_src[k] != 2'd0) return 1'b0;
    if (tmr_count[k] <= {8'd0, el}) begin
      tmr_count[k] = tmr_latch[k];
      return 1'b1;
    end
    tmr_count[k] = tmr_count[k] - {8'd0, el};
    return 1'b0;
  endfunction

  // Applies one bus item to the shadow state and returns the expected result.
  function automatic timer_result_t apply_bus_item(logic [1:0] op, logic [3:0] addr,
                                                   logic [7:0] data, logic [7:0] el);
    timer_result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        for (int k = 0; k < 2; k++) begin
          if (timer_expired(k, el)) begin
            irq_flag[k] = 1'b1;
            if (irq_mask[k]) r.irq = 1'b1;
          end
        end
      end
      OP_READ: begin
        case (addr)
          REG_TA_LO: r.rd = tmr_count[0][7:0];
          REG_TA_HI: r.rd = tmr_count[0][15:8];
          REG_TB_LO: r.rd = tmr_count[1][7:0];
          REG_TB_HI: r.rd = tmr_count[1][15:8];
          REG_ICR: begin
            r.rd[0] = irq_flag[0];
            r.rd[1] = irq_flag[1];
            r.rd[BIT_SETCL] = (irq_flag[0] && irq_mask[0]) || (irq_flag[1] && irq_mask[1]);
            irq_flag[0] = 1'b0;
            irq_flag[1] = 1'b0;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (addr)
          REG_TA_LO: tmr_latch[0][7:0] = data;
          REG_TA_HI: tmr_latch[0][15:8] = data;
          REG_TB_LO: tmr_latch[1][7:0] = data;
          REG_TB_HI: tmr_latch[1][15:8] = data;
          REG_ICR: begin
            if (data[0]) irq_mask[0] = data[BIT_SETCL];
            if (data[1]) irq_mask[1] = data[BIT_SETCL];
          end
          REG_CRA: begin
            tmr_run[0] = data[BIT_RUN];
            tmr_src[0] = {1'b0, data[BIT_SRC]};
            if (data[BIT_LOAD]) tmr_count[0] = tmr_latch[0];
          end
          REG_CRB: begin
            tmr_run[1] = data[BIT_RUN];
            tmr_src[1] = data[BIT_SRC +: 2];
            if (data[BIT_LOAD]) tmr_count[1] = tmr_latch[1];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Adds one item to the send queue; no-ops and unmapped writes are not counted.
  task automatic queue_item(logic [1:0] op, logic [3:0] addr, logic [7:0] data,
                            logic [7:0] el);
    bus_item_t it;
    bit ignored;
    it.op = op;
    it.addr = addr;
    it.data = data;
    it.elapsed = el;
    it.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
    ignored = (op == OP_NONE) ||
              (op == OP_WRITE && !(addr inside {REG_TA_LO, REG_TA_HI, REG_TB_LO,
                                                REG_TB_HI, REG_ICR, REG_CRA, REG_CRB}));
    if (!ignored) live_items++;
  endtask

  // Result check first, then prediction for the transfer taken at this edge.
  always @(posedge clk) begin : monitor
    timer_result_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (irq_pulse) n_irq++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: read_data=%h irq_pulse=%b",
                   $time, read_data, irq_pulse);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.rd) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.rd, read_data);
            err_count++;
          end
          if (irq_pulse !== want.irq) begin
            $display("%0t: irq_pulse mismatch: expected %b, actual %b",
                     $time, want.irq, irq_pulse);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        item_taken = 1'b1;
        taken_count++;
        case (opcode)
          OP_TICK: n_ticks++;
          OP_READ: begin
            n_reads++;
            if (reg_addr == REG_ICR && (irq_flag[0] || irq_flag[1])) n_flag_reads++;
          end
          OP_WRITE: n_writes++;
          default: ;
        endcase
        expected_results.push_back(apply_bus_item(opcode, reg_addr, write_data,
                                                  elapsed_cycles));
      end
      // One stretch of the run goes without any idling on either side.
      idle_pct = (taken_count >= 1000 && taken_count < 1300) ? 0 : 30;
    end
  end

  // Sender: offers the next queued item once the previous transfer is done.
  always @(negedge clk) begin : sender
    bus_item_t nxt;
    bit go;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      go = pending_items.size() != 0;
      if (go && pending_items[0].wait_drain && expected_results.size() != 0) go = 1'b0;
      if (go && $urandom_range(99) < idle_pct) go = 1'b0;
      if (go) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode <= nxt.op;
        reg_addr <= nxt.addr;
        write_data <= nxt.data;
        elapsed_cycles <= nxt.elapsed;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off so the block fills up.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && taken_count >= 700) begin
      hold_done <= 1'b1;
      hold_cycles <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] lo, hi, ctl, icr, el;
    logic [3:0] a;
    int sel, tmr, target;
    bit mid_drain;
    mid_drain = 1'b0;

    // The shadow state starts as the block does after reset.
    for (int k = 0; k < 2; k++) begin
      tmr_latch[k] = '0;
      tmr_count[k] = '0;
      tmr_src[k] = '0;
      tmr_run[k] = 1'b0;
      irq_mask[k] = 1'b0;
      irq_flag[k] = 1'b0;
    end

    // Directed part: latch extremes, zero counter, all registers and opcodes.
    queue_item(OP_TICK, 4'd0, 8'h00, 8'h00);
    queue_item(OP_WRITE, REG_TA_LO, 8'hff, 8'h00);
    queue_item(OP_WRITE, REG_TA_HI, 8'hff, 8'h00);
    queue_item(OP_WRITE, REG_TB_LO, 8'h00, 8'h00);
    queue_item(OP_WRITE, REG_TB_HI, 8'h00, 8'h00);
    queue_item(OP_WRITE, REG_ICR, 8'h83, 8'h00);       // set both masks
    queue_item(OP_WRITE, REG_CRA, 8'h11, 8'h00);       // run and load A
    queue_item(OP_WRITE, REG_CRB, 8'h11, 8'h00);       // run and load B (zero)
    queue_item(OP_TICK, 4'd0, 8'h00, 8'h00);           // zero counter with zero elapsed
    queue_item(OP_TICK, 4'd0, 8'h00, 8'hff);
    queue_item(OP_READ, REG_TA_LO, 8'h00, 8'h00);
    queue_item(OP_READ, REG_TA_HI, 8'h00, 8'h00);
    queue_item(OP_READ, REG_TB_LO, 8'h00, 8'h00);
    queue_item(OP_READ, REG_TB_HI, 8'h00, 8'h00);
    queue_item(OP_READ, REG_ICR, 8'h00, 8'h00);        // flags, then cleared
    queue_item(OP_READ, REG_ICR, 8'h00, 8'h00);
    queue_item(OP_READ, REG_CRA, 8'h00, 8'h00);
    queue_item(OP_READ, REG_CRB, 8'h00, 8'h00);
    queue_item(OP_READ, 4'd0, 8'h00, 8'h00);
    queue_item(OP_WRITE, 4'd3, 8'haa, 8'h00);          // unmapped register
    queue_item(OP_WRITE, REG_CRB, 8'h61, 8'h00);       // running, other source
    queue_item(OP_WRITE, REG_CRA, 8'h21, 8'h00);
    queue_item(OP_TICK, 4'd0, 8'h00, 8'hff);
    queue_item(OP_NONE, 4'hf, 8'hff, 8'hff);
    queue_item(OP_WRITE, REG_ICR, 8'h03, 8'h00);       // clear both masks
    queue_item(OP_WRITE, REG_CRA, 8'h10, 8'h00);       // load while stopped
    queue_item(OP_WRITE, REG_CRA, 8'h01, 8'h00);
    queue_item(OP_TICK, 4'd0, 8'h00, 8'hff);
    queue_item(OP_READ, REG_TA_HI, 8'h00, 8'h00);

    // Random part: mostly timer programming and ticks that underflow often.
    target = live_items + RANDOM_ITEMS;
    drain_next = 1'b1;
    while (live_items < target) begin
      if (!mid_drain && live_items > target - 350) begin
        mid_drain = 1'b1;
        drain_next = 1'b1;
      end
      sel = $urandom_range(99);
      el = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32));
      if (sel < 12) begin
        tmr = $urandom_range(1);
        lo = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
        hi = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00;
        ctl = 8'($urandom_range(255));
        if ($urandom_range(4) != 0) begin
          ctl[BIT_RUN] = 1'b1;
          ctl[BIT_LOAD] = 1'b1;
          ctl[BIT_SRC +: 2] = 2'd0;
        end
        queue_item(OP_WRITE, tmr ? REG_TB_LO : REG_TA_LO, lo, el);
        queue_item(OP_WRITE, tmr ? REG_TB_HI : REG_TA_HI, hi, 8'($urandom_range(255)));
        queue_item(OP_WRITE, tmr ? REG_CRB : REG_CRA, ctl, 8'($urandom_range(255)));
      end else if (sel < 18) begin
        icr = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) icr[BIT_SETCL] = 1'b1;
        queue_item(OP_WRITE, REG_ICR, icr, el);
      end else if (sel < 60) begin
        queue_item(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)), el);
      end else if (sel < 85) begin
        case ($urandom_range(5))
          0: a = REG_TA_LO;
          1: a = REG_TA_HI;
          2: a = REG_TB_LO;
          3: a = REG_TB_HI;
          4: a = REG_ICR;
          default: a = 4'($urandom_range(15));
        endcase
        queue_item(OP_READ, a, 8'($urandom_range(255)), el);
      end else begin
        queue_item(2'($urandom_range(3)), 4'($urandom_range(15)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end

    // Wait for every item to be sent and every result to arrive.
    @(negedge clk);
    while (rst || pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d transfers: %0d ticks, %0d reads, %0d writes.",
             taken_count, n_ticks, n_reads, n_writes);
    $display("Saw %0d interrupt pulses and %0d status reads with flags set.",
             n_irq, n_flag_reads);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Reset is held only at the start of the run, then released.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

endmodule
